>>> hdl/mulaw_compand_real_macros.svh
// Assertion macros shared by the compander's checker.
// Depends on nothing; the using scope must provide clk and rst.
`ifndef MULAW_COMPAND_REAL_MACROS_SVH
`define MULAW_COMPAND_REAL_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("compander check failed");

// Next-cycle implication, disabled while reset is high.
`define MCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("compander check failed");

`endif

>>> hdl/mcr_pkg.sv
// Shared constants, stage records and the root table function of the compander.
// Depends on nothing; the top level, log, exp and divider files refer to it by scoped names.
package mcr_pkg;

  localparam int LOG_FRAC   = 28;
  localparam int MANT_FRAC  = 30;
  localparam int LOG_STAGES = 28;
  localparam int EXP_STAGES = 28;
  localparam int DIV_BITS   = 16;

  localparam logic [15:0] MU_RESET      = 16'hFF00;
  localparam logic        KIND_COMPRESS = 1'b0;
  localparam logic        KIND_EXPAND   = 1'b1;

  typedef struct packed {
    logic [30:0] m_num;
    logic [30:0] m_den;
    logic [27:0] fr_num;
    logic [27:0] fr_den;
    logic [3:0]  int_num;
    logic [3:0]  int_den;
    logic        kind;
    logic        neg;
    logic [15:0] mag;
  } log_stage_t;

  typedef struct packed {
    logic [31:0] p;
    logic [27:0] f;
    logic [3:0]  k;
    logic        kind;
    logic        neg;
    logic [47:0] dc;
    logic [31:0] den;
  } exp_stage_t;

  typedef struct packed {
    logic [47:0] dvd;
    logic [31:0] dvs;
    logic        neg;
  } div_in_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [15:0] low;
    logic [15:0] q;
    logic [31:0] dvs;
    logic        ovf;
    logic        neg;
  } div_stage_t;

  // Root 2^(2^-idx) in Q2.30, built by repeated truncated square roots of 2.0.
  function automatic logic [31:0] exp_root(input int unsigned idx);
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    r = 64'd2 << 30;
    for (int unsigned i = 1; i <= idx; i++) begin
      v   = r << 30;
      res = 64'd0;
      bw  = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= res + bw) begin
          v   = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
      r = res;
    end
    return r[31:0];
  endfunction

endpackage

>>> hdl/mulaw_compand_real.sv
// Throughput: one request per cycle while the result is not stalled; the squaring,
// root multiply and divider chains are fully pipelined with one multiply per lane or one
// quotient bit per stage.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and sets mu to 255.0.
module mulaw_compand_real (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  logic        kind,
  input  logic signed [15:0] sample_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic signed [15:0] sample_out
);

  // Configuration register. A stored zero acts as the smallest step.
  logic [15:0] mu_q8_8;
  logic [15:0] mu_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_q8_8 <= mcr_pkg::MU_RESET;
    end else if (cfg_we) begin
      mu_q8_8 <= cfg_wdata;
    end
  end

  assign mu_eff = (mu_q8_8 == 16'd0) ? 16'd1 : mu_q8_8;

  // The pipeline advances as a whole whenever the output register can take a value.
  logic en;
  assign en           = !result_valid || !result_stall;
  assign sample_stall = !en;

  // Stage A: sign and magnitude, and the product mu*|x| for the compress argument.
  // The negation of the most negative code gives 0x8000, which is exactly 1.0.
  logic        a_valid;
  logic        a_kind;
  logic        a_neg;
  logic [15:0] a_mag;
  logic [31:0] a_prod;
  logic [15:0] mag_in;

  assign mag_in = sample_in[15] ? (16'd0 - sample_in) : sample_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind <= kind;
      a_neg  <= sample_in[15];
      a_mag  <= mag_in;
      a_prod <= {16'd0, mu_eff} * {16'd0, mag_in};
    end
  end

  // Stage B: normalize both log arguments to a Q1.30 mantissa and an integer part.
  // The compress argument is 2^23 + mu*|x|; the divisor argument is 256 + mu,
  // whose logarithm less eight is log2(1 + mu).
  logic                b_valid;
  mcr_pkg::log_stage_t b_data;
  logic [31:0]         a_arg;
  logic [16:0]         b_arg;
  logic [4:0]          pos_a;
  logic [4:0]          pos_b;
  logic [61:0]         sh_a;
  logic [46:0]         sh_b;
  mcr_pkg::log_stage_t b_next;

  always_comb begin
    a_arg = 32'h0080_0000 + a_prod;
    b_arg = 17'd256 + {1'b0, mu_eff};
    pos_a = 5'd0;
    pos_b = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (a_arg[i]) begin
        pos_a = 5'(i);
      end
    end
    for (int i = 0; i < 17; i++) begin
      if (b_arg[i]) begin
        pos_b = 5'(i);
      end
    end
    sh_a = {a_arg, 30'd0} >> pos_a;
    sh_b = {b_arg, 30'd0} >> pos_b;
    b_next.m_num   = sh_a[30:0];
    b_next.m_den   = sh_b[30:0];
    b_next.fr_num  = '0;
    b_next.fr_den  = '0;
    b_next.int_num = 4'(pos_a - 5'd23);
    b_next.int_den = 4'(pos_b - 5'd8);
    b_next.kind    = a_kind;
    b_next.neg     = a_neg;
    b_next.mag     = a_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_data <= b_next;
    end
  end

  // Twenty-eight squaring stages give the fraction bits of both logarithms.
  logic                l_valid;
  mcr_pkg::log_stage_t l_data;

  mcr_log2 u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_data   (b_data),
    .out_valid (l_valid),
    .out_data  (l_data)
  );

  // Stage C: the compress dividend, rounded by half the divisor, and the
  // expand exponent e = round(|y| * log2(1 + mu)) split into integer and fraction.
  logic                c_valid;
  mcr_pkg::exp_stage_t c_data;
  mcr_pkg::exp_stage_t c_next;
  logic [31:0]         num;
  logic [31:0]         den;
  logic [31:0]         num_clamp;
  logic [47:0]         prod_e;
  logic [47:0]         sum_e;

  always_comb begin
    num       = {l_data.int_num, l_data.fr_num};
    den       = {l_data.int_den, l_data.fr_den};
    num_clamp = (num > den) ? den : num;
    prod_e    = {32'd0, l_data.mag} * {16'd0, den};
    sum_e     = prod_e + 48'h4000;
    c_next.p    = 32'h4000_0000;
    c_next.f    = sum_e[42:15];
    c_next.k    = sum_e[46:43];
    c_next.kind = l_data.kind;
    c_next.neg  = l_data.neg;
    c_next.dc   = {1'b0, num_clamp, 15'd0} + {17'd0, den[31:1]};
    c_next.den  = den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_data <= c_next;
    end
  end

  // Twenty-eight constant-root multiplies form 2^f in Q2.30.
  logic                x_valid;
  mcr_pkg::exp_stage_t x_data;

  mcr_exp2 u_exp2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_data   (c_data),
    .out_valid (x_valid),
    .out_data  (x_data)
  );

  // Stage D: select the division. Expansion divides (2^e - 1) by mu, with mu
  // carried as Q8.8 and the result wanted in Q1.15, so the divisor is mu << 7.
  logic             d_valid;
  mcr_pkg::div_in_t d_data;
  mcr_pkg::div_in_t d_next;
  logic [46:0]      pk;
  logic [46:0]      n_exp;

  always_comb begin
    pk    = {15'd0, x_data.p} << x_data.k;
    n_exp = pk - 47'h4000_0000;
    d_next.neg = x_data.neg;
    if (x_data.kind == mcr_pkg::KIND_EXPAND) begin
      d_next.dvd = {1'b0, n_exp} + {26'd0, mu_eff, 6'd0};
      d_next.dvs = {9'd0, mu_eff, 7'd0};
    end else begin
      d_next.dvd = x_data.dc;
      d_next.dvs = x_data.den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_data <= d_next;
    end
  end

  // Seventeen stages: overflow check, then sixteen quotient bits.
  logic                q_valid;
  mcr_pkg::div_stage_t q_data;

  mcr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_data   (d_data),
    .out_valid (q_valid),
    .out_data  (q_data)
  );

  // Stage E: saturate and apply the sign. A negative magnitude of exactly 1.0
  // maps to the most negative code; a positive one clips to the largest code.
  logic [15:0] res_next;

  always_comb begin
    if (q_data.neg) begin
      if (q_data.ovf || (q_data.q > 16'h8000)) begin
        res_next = 16'h8000;
      end else begin
        res_next = 16'd0 - q_data.q;
      end
    end else begin
      if (q_data.ovf || q_data.q[15]) begin
        res_next = 16'h7FFF;
      end else begin
        res_next = q_data.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_out <= res_next;
    end
  end

endmodule

>>> hdl/mcr_log2.sv
// Squaring pipeline that produces the fraction bits of two base-2 logarithms.
// Depends on mcr_pkg.
module mcr_log2 (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  mcr_pkg::log_stage_t in_data,
  output logic                out_valid,
  output mcr_pkg::log_stage_t out_data
);

  mcr_pkg::log_stage_t st  [0:mcr_pkg::LOG_STAGES];
  logic                vld [0:mcr_pkg::LOG_STAGES];

  assign st[0]  = in_data;
  assign vld[0] = in_valid;

  for (genvar g = 0; g < mcr_pkg::LOG_STAGES; g++) begin : g_sq
    logic [61:0]         sq_num;
    logic [61:0]         sq_den;
    logic [31:0]         t_num;
    logic [31:0]         t_den;
    mcr_pkg::log_stage_t nxt;

    // One squaring per lane; a square at or above 2.0 yields a one bit.
    always_comb begin
      sq_num = {31'd0, st[g].m_num} * {31'd0, st[g].m_num};
      sq_den = {31'd0, st[g].m_den} * {31'd0, st[g].m_den};
      t_num  = sq_num[61:30];
      t_den  = sq_den[61:30];
      nxt        = st[g];
      nxt.m_num  = t_num[31] ? t_num[31:1] : t_num[30:0];
      nxt.m_den  = t_den[31] ? t_den[31:1] : t_den[30:0];
      nxt.fr_num = {st[g].fr_num[26:0], t_num[31]};
      nxt.fr_den = {st[g].fr_den[26:0], t_den[31]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[mcr_pkg::LOG_STAGES];
  assign out_data  = st[mcr_pkg::LOG_STAGES];

endmodule

>>> hdl/mcr_exp2.sv
// Pipeline that forms 2^f by multiplying constant roots for each set fraction bit.
// Depends on mcr_pkg.
module mcr_exp2 (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  mcr_pkg::exp_stage_t in_data,
  output logic                out_valid,
  output mcr_pkg::exp_stage_t out_data
);

  mcr_pkg::exp_stage_t st  [0:mcr_pkg::EXP_STAGES];
  logic                vld [0:mcr_pkg::EXP_STAGES];

  assign st[0]  = in_data;
  assign vld[0] = in_valid;

  for (genvar g = 0; g < mcr_pkg::EXP_STAGES; g++) begin : g_mul
    localparam logic [31:0] ROOT = mcr_pkg::exp_root(g + 1);
    logic [63:0]         prod;
    logic [63:0]         rnd;
    mcr_pkg::exp_stage_t nxt;

    always_comb begin
      prod = {32'd0, st[g].p} * {32'd0, ROOT};
      rnd  = prod + (64'd1 << 29);
      nxt  = st[g];
      if (st[g].f[mcr_pkg::LOG_FRAC-1-g]) begin
        nxt.p = rnd[61:30];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[mcr_pkg::EXP_STAGES];
  assign out_data  = st[mcr_pkg::EXP_STAGES];

endmodule

>>> hdl/mcr_div.sv
// Restoring divider pipeline, one quotient bit per stage, with an overflow flag.
// Depends on mcr_pkg.
module mcr_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  mcr_pkg::div_in_t    in_data,
  output logic                out_valid,
  output mcr_pkg::div_stage_t out_data
);

  mcr_pkg::div_stage_t st  [0:mcr_pkg::DIV_BITS];
  logic                vld [0:mcr_pkg::DIV_BITS];
  mcr_pkg::div_stage_t first;

  // The quotient overflows its sixteen bits when the upper dividend reaches the divisor.
  always_comb begin
    first.rem = in_data.dvd[47:16];
    first.low = in_data.dvd[15:0];
    first.q   = '0;
    first.dvs = in_data.dvs;
    first.ovf = (in_data.dvd[47:16] >= in_data.dvs);
    first.neg = in_data.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= first;
    end
  end

  for (genvar g = 0; g < mcr_pkg::DIV_BITS; g++) begin : g_bit
    logic [32:0]         t;
    logic [32:0]         diff;
    logic                ge;
    mcr_pkg::div_stage_t nxt;

    always_comb begin
      t    = {st[g].rem, st[g].low[15]};
      diff = t - {1'b0, st[g].dvs};
      ge   = (t >= {1'b0, st[g].dvs});
      nxt     = st[g];
      nxt.rem = ge ? diff[31:0] : t[31:0];
      nxt.low = {st[g].low[14:0], 1'b0};
      nxt.q   = {st[g].q[14:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[mcr_pkg::DIV_BITS];
  assign out_data  = st[mcr_pkg::DIV_BITS];

endmodule

>>> hdl/mcr_checker.sv
// Port-level checks of the compander's flow control, bound to the top level.
// Depends on mulaw_compand_real_macros.svh and mulaw_compand_real.
`include "mulaw_compand_real_macros.svh"

module mcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [15:0] sample_out
);

  // A held result keeps its value until it is taken.
  `MCR_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(sample_out))

  // With room at the output the block always takes a request.
  `MCR_ASSERT_NOW(a_flow, !result_valid || !result_stall, !sample_stall)

  // Back-pressure on the input only ever comes from a stalled output.
  `MCR_ASSERT_NOW(a_cause, sample_stall, result_valid && result_stall)

endmodule

bind mulaw_compand_real mcr_checker u_mcr_checker (.*);
